// ===== rtl/nlt_pkg.sv =====
// ----------------------------------------------------------------------------
// nlt_pkg
// Shared sizes, codes and interface types of the neighbor latency table.
// ----------------------------------------------------------------------------
package nlt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);
  localparam logic [FILL_W-1:0] LAST_IDX = FILL_W'(TABLE_ENTRIES - 1);

  localparam int ADDR_W = 16;
  localparam int TIME_W = 32;
  localparam int PKT_W  = 16;
  localparam int SUM_W  = 48;
  localparam int CNT_W  = 16;
  localparam int AVG_W  = 32;
  localparam int DIFF_W = TIME_W + 1;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // input kinds
  localparam logic [1:0] MODE_ND_SENT  = 2'd0;
  localparam logic [1:0] MODE_ND_RECV  = 2'd1;
  localparam logic [1:0] MODE_ACK_SEND = 2'd2;
  localparam logic [1:0] MODE_ACK_RECV = 2'd3;

  // result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_MISSED = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/nlt_div.sv =====
// ----------------------------------------------------------------------------
// nlt_div
// Signed 48-bit by unsigned 16-bit divider, restoring, one quotient bit per
// cycle; quotient truncated toward zero.
// ----------------------------------------------------------------------------
module nlt_div (
  input  logic                             clk,
  input  logic                             rst,
  input  nlt_pkg::div_ctrl_t               ctrl,
  input  logic signed [nlt_pkg::SUM_W-1:0] dividend,
  input  logic        [nlt_pkg::CNT_W-1:0] divisor,
  output nlt_pkg::div_stat_t               stat,
  output logic signed [nlt_pkg::SUM_W-1:0] quotient
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t                     state;
  logic                        neg;
  logic [nlt_pkg::SUM_W-1:0]   q;
  logic [nlt_pkg::CNT_W-1:0]   rem;
  logic [nlt_pkg::CNT_W-1:0]   dvs;
  logic [nlt_pkg::STEP_W-1:0]  step;
  logic                        done;

  logic [nlt_pkg::CNT_W:0]     rem_sh;
  logic [nlt_pkg::CNT_W:0]     rem_sub;
  logic                        qbit;

  assign rem_sh  = {rem, q[nlt_pkg::SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign qbit    = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_FIX);
      case (state)
        D_IDLE: begin
          if (ctrl.start) begin
            neg   <= dividend[nlt_pkg::SUM_W-1];
            q     <= dividend[nlt_pkg::SUM_W-1] ? -dividend : dividend;
            rem   <= '0;
            dvs   <= divisor;
            step  <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          q    <= {q[nlt_pkg::SUM_W-2:0], qbit};
          rem  <= qbit ? rem_sub[nlt_pkg::CNT_W-1:0] : rem_sh[nlt_pkg::CNT_W-1:0];
          step <= step + 1'b1;
          if (step == nlt_pkg::STEP_W'(nlt_pkg::SUM_W - 1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          q     <= neg ? -q : q;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign quotient  = q;
  assign stat.busy = (state != D_IDLE);
  assign stat.done = done;

endmodule

// ===== rtl/neighbor_latency_table.sv =====
// ----------------------------------------------------------------------------
// neighbor_latency_table
// Neighbor-discovery timing engine: packet numbering, arrival table dump and
// per-neighbor one-way latency averaging.
// ----------------------------------------------------------------------------
// One transaction at a time. Modes 0 and 1 go from idle to the emit state,
// which loads the output register. Mode 2 emits TABLE_ENTRIES results, one
// per cycle while m_tready is high. Mode 3 with peer_saw_ours set runs a
// linear search of the latency table at one entry per cycle; then the
// restoring divider, with its shift steps, a sign fix and the hand-back of
// the quotient, forms the average. s_tready is high only while the engine
// is idle.
module neighbor_latency_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // peer_addr[15:0], time_now[47:16], peer_send_time[79:48],
  // peer_arrival_time[111:80], peer_saw_ours[112], zero pad
  input  logic [119:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // packet_number[15:0], entry_valid[16], entry_addr[32:17],
  // entry_time[64:33], latency_avg[96:65], sample_count[112:97], zero pad
  output logic [119:0] m_tdata,
  // status[1:0]
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SEARCH, S_UPDATE, S_DIVSTART, S_DIVWAIT, S_EMIT, S_DUMP
  } state_t;

  state_t state;

  // input fields
  logic [1:0]                  in_mode;
  logic [nlt_pkg::ADDR_W-1:0]  in_peer;
  logic [nlt_pkg::TIME_W-1:0]  in_t4;
  logic [nlt_pkg::TIME_W-1:0]  in_t3;
  logic [nlt_pkg::TIME_W-1:0]  in_t2;
  logic                        in_saw;

  assign in_mode = s_tuser;
  assign in_peer = s_tdata[15:0];
  assign in_t4   = s_tdata[47:16];
  assign in_t3   = s_tdata[79:48];
  assign in_t2   = s_tdata[111:80];
  assign in_saw  = s_tdata[112];

  // persistent state
  logic [nlt_pkg::TIME_W-1:0]  last_sent;
  logic [nlt_pkg::PKT_W-1:0]   seq;
  logic [nlt_pkg::ADDR_W-1:0]  arr_addr [nlt_pkg::TABLE_ENTRIES];
  logic [nlt_pkg::TIME_W-1:0]  arr_time [nlt_pkg::TABLE_ENTRIES];
  logic [nlt_pkg::FILL_W-1:0]  arr_fill;
  logic [nlt_pkg::ADDR_W-1:0]  nb_addr  [nlt_pkg::TABLE_ENTRIES];
  logic signed [nlt_pkg::SUM_W-1:0] nb_sum [nlt_pkg::TABLE_ENTRIES];
  logic [nlt_pkg::CNT_W-1:0]   nb_count [nlt_pkg::TABLE_ENTRIES];
  logic [nlt_pkg::FILL_W-1:0]  nb_fill;

  // per-transaction working registers
  logic [nlt_pkg::ADDR_W-1:0]  peer;
  logic [nlt_pkg::TIME_W-1:0]  d1;
  logic [nlt_pkg::TIME_W-1:0]  d2;
  logic signed [nlt_pkg::DIFF_W-1:0] diff;
  logic signed [nlt_pkg::DIFF_W-1:0] sample;
  logic [nlt_pkg::FILL_W-1:0]  idx;
  logic [nlt_pkg::IDX_W-1:0]   slot;
  logic signed [nlt_pkg::SUM_W-1:0] cur_sum;
  logic [nlt_pkg::CNT_W-1:0]   cur_count;
  logic [1:0]                  res_status;
  logic [nlt_pkg::PKT_W-1:0]   res_pkt;
  logic [nlt_pkg::AVG_W-1:0]   res_avg;
  logic [nlt_pkg::CNT_W-1:0]   res_count;

  // output register
  logic [1:0]                  out_status;
  logic [nlt_pkg::PKT_W-1:0]   out_pkt;
  logic                        out_evalid;
  logic [nlt_pkg::ADDR_W-1:0]  out_eaddr;
  logic [nlt_pkg::TIME_W-1:0]  out_etime;
  logic [nlt_pkg::AVG_W-1:0]   out_avg;
  logic [nlt_pkg::CNT_W-1:0]   out_count;
  logic                        out_last;
  logic                        out_free;
  logic                        out_load;

  // divider
  nlt_pkg::div_ctrl_t               div_ctrl;
  nlt_pkg::div_stat_t               div_stat;
  logic signed [nlt_pkg::SUM_W-1:0] div_quot;

  logic [nlt_pkg::IDX_W-1:0]        ridx;
  logic                             dump_valid;
  logic signed [nlt_pkg::SUM_W-1:0] sum_next;

  function automatic logic signed [nlt_pkg::DIFF_W-1:0] DIFF_ONE(
    input logic signed [nlt_pkg::DIFF_W-1:0] v
  );
    DIFF_ONE = {{(nlt_pkg::DIFF_W-1){1'b0}}, v[nlt_pkg::DIFF_W-1]};
  endfunction

  assign ridx       = idx[nlt_pkg::IDX_W-1:0];
  assign out_free   = !m_tvalid || m_tready;
  assign out_load   = out_free && (state == S_EMIT || state == S_DUMP);
  assign s_tready   = (state == S_IDLE);
  assign dump_valid = (idx < arr_fill);
  assign sum_next   = cur_sum + nlt_pkg::SUM_W'(sample);
  assign div_ctrl.start = (state == S_DIVSTART);

  nlt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (cur_sum),
    .divisor  (cur_count),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      last_sent <= '0;
      seq       <= '0;
      arr_fill  <= '0;
      nb_fill   <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      // sample = (d1 - d2) / 2, truncated toward zero
      sample <= (diff + DIFF_ONE(diff)) >>> 1;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            res_avg    <= '0;
            res_count  <= '0;
            peer       <= in_peer;
            d1         <= in_t4 - last_sent;
            d2         <= in_t3 - in_t2;
            idx        <= '0;
            case (in_mode)
              nlt_pkg::MODE_ND_SENT: begin
                res_status <= nlt_pkg::ST_OK;
                res_pkt    <= seq;
                seq        <= seq + 1'b1;
                last_sent  <= in_t4;
                state      <= S_EMIT;
              end
              nlt_pkg::MODE_ND_RECV: begin
                res_pkt <= '0;
                if (arr_fill == nlt_pkg::FILL_MAX) begin
                  res_status <= nlt_pkg::ST_FULL;
                end else begin
                  res_status <= nlt_pkg::ST_OK;
                  arr_addr[arr_fill[nlt_pkg::IDX_W-1:0]] <= in_peer;
                  arr_time[arr_fill[nlt_pkg::IDX_W-1:0]] <= in_t4;
                  arr_fill <= arr_fill + 1'b1;
                end
                state <= S_EMIT;
              end
              nlt_pkg::MODE_ACK_SEND: begin
                res_status <= nlt_pkg::ST_OK;
                res_pkt    <= seq;
                seq        <= seq + 1'b1;
                state      <= S_DUMP;
              end
              default: begin
                res_pkt <= '0;
                if (in_saw) begin
                  res_status <= nlt_pkg::ST_OK;
                  state      <= S_PREP;
                end else begin
                  res_status <= nlt_pkg::ST_MISSED;
                  state      <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_PREP: begin
          diff  <= $signed({1'b0, d1}) - $signed({1'b0, d2});
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (idx == nb_fill) begin
            if (nb_fill == nlt_pkg::FILL_MAX) begin
              res_status <= nlt_pkg::ST_FULL;
              state      <= S_EMIT;
            end else begin
              nb_addr[ridx] <= peer;
              slot      <= ridx;
              cur_sum   <= '0;
              cur_count <= '0;
              nb_fill   <= nb_fill + 1'b1;
              state     <= S_UPDATE;
            end
          end else if (nb_addr[ridx] == peer) begin
            slot      <= ridx;
            cur_sum   <= nb_sum[ridx];
            cur_count <= nb_count[ridx];
            state     <= S_UPDATE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_UPDATE: begin
          if (cur_count == nlt_pkg::CNT_MAX) begin
            res_status <= nlt_pkg::ST_SAT;
          end else begin
            nb_sum[slot]   <= sum_next;
            nb_count[slot] <= cur_count + 1'b1;
            cur_sum        <= sum_next;
            cur_count      <= cur_count + 1'b1;
          end
          state <= S_DIVSTART;
        end
        S_DIVSTART: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_stat.done) begin
            res_avg   <= div_quot[nlt_pkg::AVG_W-1:0];
            res_count <= cur_count;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_status <= res_status;
            out_pkt    <= res_pkt;
            out_evalid <= 1'b0;
            out_eaddr  <= '0;
            out_etime  <= '0;
            out_avg    <= res_avg;
            out_count  <= res_count;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_status <= nlt_pkg::ST_OK;
            out_pkt    <= res_pkt;
            out_evalid <= dump_valid;
            out_eaddr  <= dump_valid ? arr_addr[ridx] : '0;
            out_etime  <= dump_valid ? arr_time[ridx] : '0;
            out_avg    <= '0;
            out_count  <= '0;
            out_last   <= (idx == nlt_pkg::LAST_IDX);
            idx        <= idx + 1'b1;
            if (idx == nlt_pkg::LAST_IDX) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, out_count, out_avg, out_etime, out_eaddr, out_evalid, out_pkt};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // no new transaction while the divider works
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !s_tready)
    else $error("input accepted while divider busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIVWAIT)
    else $error("divider result outside of wait state");

  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP && out_free && idx == nlt_pkg::LAST_IDX) |=> state == S_IDLE)
    else $error("dump did not end after last slot");

  a_arr_fill_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (arr_fill >= $past(arr_fill) && arr_fill <= nlt_pkg::FILL_MAX))
    else $error("arrival fill out of range or shrinking");

  a_nb_fill_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (nb_fill >= $past(nb_fill) && nb_fill <= nlt_pkg::FILL_MAX))
    else $error("neighbor fill out of range or shrinking");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for neighbor_latency_table. Directed corner cases come
// first. A burst without any idling then feeds one neighbor the largest
// samples. Random discovery traffic follows. Every result is checked against
// a predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF     = 6;
  localparam int          IDLE_PCT     = 6;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          TAIL_CYCLES  = 100;
  localparam int          RANDOM_ITEMS = 320;
  localparam int          STEADY_ITEMS = 40;
  localparam int          POOL_SIZE    = 20;
  localparam logic [15:0] SAT_PEER     = 16'hA5C3;

  typedef struct {
    logic [1:0]                 mode;
    logic [nlt_pkg::ADDR_W-1:0] peer;
    logic [nlt_pkg::TIME_W-1:0] t_now;      // t4, or send time in mode 0
    logic [nlt_pkg::TIME_W-1:0] t_peer_tx;  // t3
    logic [nlt_pkg::TIME_W-1:0] t_peer_rx;  // t2
    logic                       saw;
    bit                         steady;     // part of the no-idle burst
  } nd_event_t;

  typedef struct {
    logic [1:0]                 status;
    logic [nlt_pkg::PKT_W-1:0]  pkt;
    logic                       ent_valid;
    logic [nlt_pkg::ADDR_W-1:0] ent_addr;
    logic [nlt_pkg::TIME_W-1:0] ent_time;
    logic [nlt_pkg::AVG_W-1:0]  avg;
    logic [nlt_pkg::CNT_W-1:0]  cnt;
    logic                       last;
  } nd_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  neighbor_latency_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #(CLK_HALF) clk = ~clk;

  // stimulus and expectations
  nd_event_t  nd_events[$];
  nd_result_t awaited_results[$];
  nd_event_t  drv_item;
  logic       steady_run = 1'b0;
  int         queued_items = 0;
  int         taken_items = 0;
  int         err_cnt = 0;
  int         quiet_cycles = 0;
  logic [nlt_pkg::TIME_W-1:0] gen_last_sent = '0;

  // predictor state
  logic [nlt_pkg::TIME_W-1:0] p_last_sent;
  logic [nlt_pkg::PKT_W-1:0]  p_seq;
  logic                       p_arr_valid [nlt_pkg::TABLE_ENTRIES];
  logic [nlt_pkg::ADDR_W-1:0] p_arr_addr  [nlt_pkg::TABLE_ENTRIES];
  logic [nlt_pkg::TIME_W-1:0] p_arr_time  [nlt_pkg::TABLE_ENTRIES];
  int                         p_arr_fill;
  logic [nlt_pkg::ADDR_W-1:0] p_nb_addr   [nlt_pkg::TABLE_ENTRIES];
  longint                     p_nb_sum    [nlt_pkg::TABLE_ENTRIES];
  logic [nlt_pkg::CNT_W-1:0]  p_nb_cnt    [nlt_pkg::TABLE_ENTRIES];
  int                         p_nb_fill;

  initial begin : pred_init
    p_last_sent = '0;
    p_seq       = '0;
    p_arr_fill  = 0;
    p_nb_fill   = 0;
    for (int i = 0; i < nlt_pkg::TABLE_ENTRIES; i++) begin
      p_arr_valid[i] = 1'b0;
      p_arr_addr[i]  = '0;
      p_arr_time[i]  = '0;
      p_nb_addr[i]   = '0;
      p_nb_sum[i]    = 0;
      p_nb_cnt[i]    = '0;
    end
  end

  function automatic logic [119:0] pack_event(input nd_event_t ev);
    return {7'b0, ev.saw, ev.t_peer_rx, ev.t_peer_tx, ev.t_now, ev.peer};
  endfunction

  function automatic logic [nlt_pkg::AVG_W-1:0] avg_of(input int slot);
    longint q;
    q = p_nb_sum[slot] / longint'({48'b0, p_nb_cnt[slot]});
    return q[nlt_pkg::AVG_W-1:0];
  endfunction

  // Updates the tables for one accepted event and queues its results.
  task automatic forecast_results(input nd_event_t ev);
    nd_result_t r;
    logic [nlt_pkg::TIME_W-1:0] d1, d2;
    longint sample;
    int slot;
    r = '{default: '0};
    r.last = 1'b1;
    case (ev.mode)
      nlt_pkg::MODE_ND_SENT: begin
        r.pkt = p_seq;
        p_seq = p_seq + 1'b1;
        p_last_sent = ev.t_now;
        awaited_results.push_back(r);
      end
      nlt_pkg::MODE_ND_RECV: begin
        if (p_arr_fill >= nlt_pkg::TABLE_ENTRIES) begin
          r.status = nlt_pkg::ST_FULL;
        end else begin
          p_arr_valid[p_arr_fill] = 1'b1;
          p_arr_addr[p_arr_fill]  = ev.peer;
          p_arr_time[p_arr_fill]  = ev.t_now;
          p_arr_fill++;
        end
        awaited_results.push_back(r);
      end
      nlt_pkg::MODE_ACK_SEND: begin
        for (int i = 0; i < nlt_pkg::TABLE_ENTRIES; i++) begin
          r.status    = nlt_pkg::ST_OK;
          r.pkt       = p_seq;
          r.ent_valid = p_arr_valid[i];
          r.ent_addr  = p_arr_valid[i] ? p_arr_addr[i] : '0;
          r.ent_time  = p_arr_valid[i] ? p_arr_time[i] : '0;
          r.last      = (i == nlt_pkg::TABLE_ENTRIES - 1);
          awaited_results.push_back(r);
        end
        p_seq = p_seq + 1'b1;
      end
      default: begin
        if (!ev.saw) begin
          r.status = nlt_pkg::ST_MISSED;
        end else begin
          d1 = ev.t_now - p_last_sent;
          d2 = ev.t_peer_tx - ev.t_peer_rx;
          // signed divide truncates toward zero
          sample = (longint'({32'b0, d1}) - longint'({32'b0, d2})) / 2;
          slot = -1;
          for (int i = 0; i < p_nb_fill; i++) begin
            if (p_nb_addr[i] == ev.peer) begin
              slot = i;
              break;
            end
          end
          if (slot < 0 && p_nb_fill < nlt_pkg::TABLE_ENTRIES) begin
            slot = p_nb_fill;
            p_nb_addr[slot] = ev.peer;
            p_nb_sum[slot]  = 0;
            p_nb_cnt[slot]  = '0;
            p_nb_fill++;
          end
          if (slot < 0) begin
            r.status = nlt_pkg::ST_FULL;
          end else if (p_nb_cnt[slot] == nlt_pkg::CNT_MAX) begin
            r.status = nlt_pkg::ST_SAT;
            r.avg    = avg_of(slot);
            r.cnt    = p_nb_cnt[slot];
          end else begin
            p_nb_sum[slot] = p_nb_sum[slot] + sample;
            p_nb_cnt[slot] = p_nb_cnt[slot] + 1'b1;
            r.avg = avg_of(slot);
            r.cnt = p_nb_cnt[slot];
          end
        end
        awaited_results.push_back(r);
      end
    endcase
  endtask

  task automatic log_mismatch(input string what);
    err_cnt++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic enqueue(input logic [1:0] mode, input logic [15:0] peer,
                         input logic [31:0] t4, input logic [31:0] t3,
                         input logic [31:0] t2, input logic saw,
                         input bit steady);
    nd_event_t ev;
    ev.mode      = mode;
    ev.peer      = peer;
    ev.t_now     = t4;
    ev.t_peer_tx = t3;
    ev.t_peer_rx = t2;
    ev.saw       = saw;
    ev.steady    = steady;
    if (mode == nlt_pkg::MODE_ND_SENT)
      gen_last_sent = t4;
    nd_events.push_back(ev);
    queued_items++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        forecast_results(drv_item);
        taken_items++;
      end
      if (!s_tvalid || s_tready) begin
        if (nd_events.size() > 0 &&
            (nd_events[0].steady || $urandom_range(99) >= IDLE_PCT)) begin
          drv_item = nd_events.pop_front();
          s_tvalid   <= 1'b1;
          s_tdata    <= pack_event(drv_item);
          s_tuser    <= drv_item.mode;
          steady_run <= drv_item.steady;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon_blk
    nd_result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status    = m_tuser;
        got.pkt       = m_tdata[15:0];
        got.ent_valid = m_tdata[16];
        got.ent_addr  = m_tdata[32:17];
        got.ent_time  = m_tdata[64:33];
        got.avg       = m_tdata[96:65];
        got.cnt       = m_tdata[112:97];
        got.last      = m_tlast;
        if (awaited_results.size() == 0) begin
          log_mismatch($sformatf("unexpected transaction, status %0d", got.status));
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("packet_number", 32'(got.pkt), 32'(want.pkt));
          check_field("entry_valid", 32'(got.ent_valid), 32'(want.ent_valid));
          check_field("entry_addr", 32'(got.ent_addr), 32'(want.ent_addr));
          check_field("entry_time", got.ent_time, want.ent_time);
          check_field("latency_avg", got.avg, want.avg);
          check_field("sample_count", 32'(got.cnt), 32'(want.cnt));
          check_field("last", 32'(got.last), 32'(want.last));
        end
      end
      m_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stim
    logic [15:0] pool [POOL_SIZE];
    logic [15:0] peer;
    logic [31:0] t2, t4;
    logic [1:0]  mode;
    int unsigned pick;

    // directed corners
    enqueue(nlt_pkg::MODE_ACK_SEND, 16'h1234, '1, '1, '1, 1'b1, 0);   // empty dump
    // before any send: last send time is zero, largest positive sample
    enqueue(nlt_pkg::MODE_ACK_RECV, 16'h0000, '1, '0, '0, 1'b1, 0);
    enqueue(nlt_pkg::MODE_ACK_RECV, 16'hFFFF, '1, '1, '0, 1'b0, 0);   // peer missed us
    enqueue(nlt_pkg::MODE_ND_SENT,  16'hFFFF, '1, '0, '0, 1'b0, 0);
    enqueue(nlt_pkg::MODE_ND_RECV,  16'hFFFF, '1, '0, '1, 1'b1, 0);
    enqueue(nlt_pkg::MODE_ND_RECV,  16'h0000, '0, '1, '0, 1'b0, 0);
    enqueue(nlt_pkg::MODE_ACK_SEND, 16'h0000, '0, '0, '0, 1'b0, 0);
    // most negative sample
    enqueue(nlt_pkg::MODE_ACK_RECV, 16'h0000, '1, '1, '0, 1'b1, 0);
    // -1/2 and -3/2 check truncation toward zero, in the average too
    enqueue(nlt_pkg::MODE_ACK_RECV, 16'h0000, '1, 32'd1, 32'd0, 1'b1, 0);
    enqueue(nlt_pkg::MODE_ACK_RECV, 16'h0000, '1, 32'd3, 32'd0, 1'b1, 0);
    enqueue(nlt_pkg::MODE_ND_SENT,  16'h0000, '0, '1, '1, 1'b1, 0);
    enqueue(nlt_pkg::MODE_ACK_RECV, 16'hFFFF, 32'd5, '0, '0, 1'b1, 0);
    // second sample for the same neighbor, d1 small and positive
    enqueue(nlt_pkg::MODE_ACK_RECV, 16'hFFFF, 32'd7, 32'd9, 32'd4, 1'b1, 0);

    // feed one neighbor the largest samples back to back;
    // this also runs the longest stretch without any idling
    enqueue(nlt_pkg::MODE_ND_SENT, 16'h0000, 32'h8000_0000, '0, '0, 1'b0, 1);
    for (int i = 0; i < STEADY_ITEMS; i++) begin
      t2 = $urandom;
      enqueue(nlt_pkg::MODE_ACK_RECV, SAT_PEER, 32'h7FFF_FFFF, t2, t2, 1'b1, 1);
    end
    enqueue(nlt_pkg::MODE_ACK_RECV, SAT_PEER, 32'h8000_0000, '1, '0, 1'b1, 0);

    // random traffic
    for (int i = 0; i < POOL_SIZE; i++)
      pool[i] = 16'($urandom);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 15)
        mode = nlt_pkg::MODE_ND_SENT;
      else if (pick < 33)
        mode = nlt_pkg::MODE_ND_RECV;
      else if (pick < 45)
        mode = nlt_pkg::MODE_ACK_SEND;
      else
        mode = nlt_pkg::MODE_ACK_RECV;
      if (mode == nlt_pkg::MODE_ACK_RECV) begin
        pick = $urandom_range(99);
        if (pick < 85)
          peer = pool[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 90)
          peer = SAT_PEER;
        else
          peer = 16'($urandom);
        if ($urandom_range(99) < 80) begin
          // plausible exchange: small round trip and turnaround
          t4 = gen_last_sent + $urandom_range(5000, 200);
          t2 = $urandom;
          enqueue(mode, peer, t4, t2 + $urandom_range(1000, 10), t2,
                  $urandom_range(9) != 0, 0);
        end else begin
          enqueue(mode, peer, $urandom, $urandom, $urandom,
                  $urandom_range(9) != 0, 0);
        end
      end else begin
        enqueue(mode, 16'($urandom), $urandom, $urandom, $urandom,
                1'($urandom), 0);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (taken_items == queued_items);
    wait (awaited_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nlt_pkg.sv
rtl/nlt_div.sv
rtl/neighbor_latency_table.sv
dv/tb_top.sv
